### src/utg_pkg.sv
package utg_pkg;

    // Byte classes of UTF-8 text
    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] CONT_LO      = 8'h80;
    localparam logic [7:0] CONT_HI      = 8'hBF;
    localparam logic [7:0] LEAD_ACCENT  = 8'hC3;
    localparam logic [7:0] LEAD2_LO     = 8'hC2;
    localparam logic [7:0] LEAD2_HI     = 8'hDF;
    localparam logic [7:0] LEAD3_LO     = 8'hE0;
    localparam logic [7:0] LEAD3_HI     = 8'hEF;
    localparam logic [7:0] LEAD4_LO     = 8'hF0;
    localparam logic [7:0] LEAD4_HI     = 8'hF4;

    // Continuation bytes to skip after each lead class
    localparam logic [1:0] SKIP_LEAD2   = 2'd1;
    localparam logic [1:0] SKIP_LEAD3   = 2'd2;
    localparam logic [1:0] SKIP_LEAD4   = 2'd3;

    localparam logic [7:0] GLYPH_NONE   = 8'd0;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_AFTER = 2'd1,
        MODE_SKIP  = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [1:0] skip;
    } t_dec_state;

    typedef struct packed {
        t_dec_state state;
        logic [7:0] glyph;
    } t_dec_result;

    localparam t_dec_state DEC_STATE_IDLE = '{mode: MODE_IDLE, skip: 2'd0};

    // Code-page value for the second byte of a 0xC3 pair (low six bits)
    function automatic logic [7:0] accent_glyph(input logic [5:0] idx);
        logic [7:0] g;
        unique case (idx)
            6'd0, 6'd32:  g = 8'd133;
            6'd2, 6'd34:  g = 8'd131;
            6'd4:         g = 8'd142;
            6'd36:        g = 8'd132;
            6'd7, 6'd39:  g = 8'd135;
            6'd8, 6'd40:  g = 8'd138;
            6'd9, 6'd41:  g = 8'd130;
            6'd10, 6'd42: g = 8'd136;
            6'd11, 6'd43: g = 8'd137;
            6'd15, 6'd47: g = 8'd139;
            6'd20, 6'd52: g = 8'd147;
            6'd22:        g = 8'd153;
            6'd54:        g = 8'd148;
            6'd25, 6'd57: g = 8'd151;
            6'd27, 6'd59: g = 8'd150;
            6'd28:        g = 8'd154;
            6'd60:        g = 8'd129;
            6'd31:        g = 8'd225;
            default:      g = GLYPH_NONE;
        endcase
        return g;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b >= CONT_LO) && (b <= CONT_HI);
    endfunction

    // Handle a byte seen with no sequence pending
    function automatic t_dec_result handle_lead(input logic [7:0] b);
        t_dec_result r;
        r.state = DEC_STATE_IDLE;
        r.glyph = GLYPH_NONE;
        priority if (b < ASCII_LIMIT) begin
            r.glyph = b;
        end else if (b == LEAD_ACCENT) begin
            r.state.mode = MODE_AFTER;
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            r.state = '{mode: MODE_SKIP, skip: SKIP_LEAD2};
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            r.state = '{mode: MODE_SKIP, skip: SKIP_LEAD3};
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            r.state = '{mode: MODE_SKIP, skip: SKIP_LEAD4};
        end else begin
            r.glyph = b;
        end
        return r;
    endfunction

endpackage

### src/utg_if.sv
interface utg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_of_text;

    modport source (output valid, output text_byte, output last_of_text, input ready);
    modport sink   (input valid, input text_byte, input last_of_text, output ready);
endinterface

interface utg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] glyph_code;

    modport source (output valid, output glyph_code, input ready);
    modport sink   (input valid, input glyph_code, output ready);
endinterface

### src/utg_decode.sv
module utg_decode (
    input  utg_pkg::t_dec_state i_state,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output utg_pkg::t_dec_state o_state,
    output logic [7:0]          o_glyph
);
    import utg_pkg::*;

    t_dec_result lead;

    assign lead = handle_lead(i_byte);

    // Decide the glyph and the next mode for one byte
    always_comb begin
        o_state = DEC_STATE_IDLE;
        o_glyph = GLYPH_NONE;
        priority if (i_state.mode == MODE_AFTER) begin
            if (is_cont(i_byte)) begin
                o_glyph = accent_glyph(i_byte[5:0]);
            end
        end else if (i_state.mode == MODE_SKIP && i_state.skip != 2'd0) begin
            if (is_cont(i_byte)) begin
                o_state.skip = i_state.skip - 2'd1;
                o_state.mode = (o_state.skip == 2'd0) ? MODE_IDLE : MODE_SKIP;
            end else begin
                o_state = lead.state;
                o_glyph = lead.glyph;
            end
        end else begin
            o_state = lead.state;
            o_glyph = lead.glyph;
        end
        // End of string drops any pending sequence
        if (i_last) begin
            o_state = DEC_STATE_IDLE;
        end
    end
endmodule

### src/utg_out_stage.sv
module utg_out_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_glyph,
    output logic       o_free,
    utg_out_if.source  o_glyph
);
    import utg_pkg::*;

    logic       r_valid;
    logic [7:0] r_glyph;

    assign o_free           = !r_valid || o_glyph.ready;
    assign o_glyph.valid    = r_valid;
    assign o_glyph.glyph_code = r_glyph;

    // Load a fresh result, drop empty ones, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= (i_glyph != GLYPH_NONE);
        end else if (o_glyph.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_glyph <= i_glyph;
        end
    end
endmodule

### src/utf8_to_legacy_glyph_map_core.sv
// UTF-8 text to legacy code-page glyph codes.
//
// i_text (sink): one byte of UTF-8 text per item, with last_of_text marking
// the final byte of a string. o_glyph (source): one glyph code per item,
// never zero. Both channels move an item when valid and ready are high.
// Each input byte yields zero or one glyph; bytes that give nothing (leads,
// continuation bytes in a sequence, NUL, unmapped accent pairs) yield none.
//
// Each byte is held in the input register until the output stage is free;
// its glyph is then registered in the output register. Throughput is one
// byte per cycle while the output stage is free, set by the single input
// register feeding the decode logic and the output register; the mode
// state updates as each byte moves on.
// While a result waits on o_glyph, one further byte is taken into the input
// register; further bytes wait until the receiver takes the result.
// Reset (synchronous, active low) empties both registers and returns the
// decoder to idle mode.
module utf8_to_legacy_glyph_map_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    utg_in_if.sink    i_text,
    utg_out_if.source o_glyph
);
    import utg_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    t_dec_state r_state;
    t_dec_state n_state;
    logic [7:0] dec_glyph;
    logic       out_free;
    logic       s1_adv;

    assign s1_adv       = r_s1_valid && out_free;
    assign i_text.ready = !r_s1_valid || s1_adv;

    // Hold the accepted byte until the output stage can take its result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_s1_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.ready && i_text.valid) begin
            r_s1_byte <= i_text.text_byte;
            r_s1_last <= i_text.last_of_text;
        end
    end

    utg_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .o_state (n_state),
        .o_glyph (dec_glyph)
    );

    // Advance the decoder mode as each byte is handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DEC_STATE_IDLE;
        end else if (s1_adv) begin
            r_state <= n_state;
        end
    end

    utg_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_adv),
        .i_glyph (dec_glyph),
        .o_free  (out_free),
        .o_glyph (o_glyph)
    );

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_SKIP) |-> (r_state.skip != 2'd0))
        else $error("skip mode with nothing left to skip");

    a_skip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode != MODE_SKIP) |-> (r_state.skip == 2'd0))
        else $error("skip count left over outside skip mode");

    a_out_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_glyph.valid |-> (o_glyph.glyph_code != GLYPH_NONE))
        else $error("zero glyph offered");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |-> !i_text.ready)
        else $error("input taken while held byte is stalled");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> (r_state == DEC_STATE_IDLE))
        else $error("state pending after end of string");
endmodule
